>>> rtl/core/sss_pkg.sv
// Shared types, constants and the segment decoder for the seven-segment scan display.
// No dependencies; used by sss_conv and seven_segment_scan_display.
package sss_pkg;

  // Digit count default and limits
  localparam int DIGITS_DEF = 4;
  localparam int ADDR_W     = 3;   // enough for up to eight digits

  // Conversion sizes
  localparam int VALUE_W    = 32;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int STEP_W     = 5;   // counts the 32 dabble steps

  // Segment patterns (active low)
  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [7:0] SEG_RESET = 8'h40;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    OP_SCAN = 2'd0,
    OP_DEC  = 2'd1,
    OP_HEX  = 2'd2,
    OP_FILL = 2'd3
  } op_t;

  // Digit store write from the converter
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // Hex digit to active-low segment byte
  function automatic logic [7:0] seg_pat(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'h0:    p = 8'hC0;
      4'h1:    p = 8'hF9;
      4'h2:    p = 8'hA4;
      4'h3:    p = 8'hB0;
      4'h4:    p = 8'h99;
      4'h5:    p = 8'h92;
      4'h6:    p = 8'h82;
      4'h7:    p = 8'hF8;
      4'h8:    p = 8'h80;
      4'h9:    p = 8'h90;
      4'hA:    p = 8'h88;
      4'hB:    p = 8'h83;
      4'hC:    p = 8'hC6;
      4'hD:    p = 8'hA1;
      4'hE:    p = 8'h86;
      default: p = 8'h8E;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/sss_conv.sv
// Value-to-digit converter: shift-and-add-3 BCD unit plus a window placer.
// Places one digit per cycle, storing in-range ones. Depends on sss_pkg.
module sss_conv #(
  parameter int DIGITS = sss_pkg::DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start_i,
  input  logic                           hex_i,
  input  logic [sss_pkg::VALUE_W-1:0]    value_i,
  input  logic [1:0]                     start_pos_i,
  input  logic [3:0]                     len_i,
  output logic                           busy_o,
  output sss_pkg::wr_t                   wr_o
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_DABBLE,
    C_PLACE
  } cstate_t;

  localparam logic [4:0] POS_LIM = 5'(DIGITS);
  localparam logic [sss_pkg::STEP_W-1:0] LAST_STEP = sss_pkg::STEP_W'(sss_pkg::VALUE_W - 1);

  cstate_t                       state_r, state_nxt;
  logic [sss_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [sss_pkg::VALUE_W-1:0]   bin_r, bin_nxt;
  logic [sss_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [3:0]                    idx_r, idx_nxt;
  logic [4:0]                    pos_r, pos_nxt;
  logic                          seen_r, seen_nxt;
  logic                          hex_r, hex_nxt;

  logic [sss_pkg::BCD_W-1:0]     bcd_adj;
  logic [3:0]                    dig;
  logic [7:0]                    pat;

  // Add 3 to every BCD nibble of 5 or more ahead of the shift
  always_comb begin
    for (int j = 0; j < sss_pkg::DEC_DIGITS; j++) begin
      bcd_adj[4*j +: 4] = (bcd_r[4*j +: 4] >= 4'd5) ? bcd_r[4*j +: 4] + 4'd3
                                                     : bcd_r[4*j +: 4];
    end
  end

  // Current digit; digits past the tenth read as zero
  assign dig = (idx_r < 4'd10) ? bcd_r[{idx_r, 2'b00} +: 4] : 4'd0;

  // Leading zeros blank in decimal, last position always shown
  always_comb begin
    if (dig != 4'd0) begin
      pat = sss_pkg::seg_pat(dig);
    end else if (seen_r || idx_r == 4'd0 || hex_r) begin
      pat = sss_pkg::seg_pat(4'd0);
    end else begin
      pat = sss_pkg::SEG_BLANK;
    end
  end

  assign busy_o       = (state_r != C_IDLE);
  assign wr_o.en      = (state_r == C_PLACE) && (pos_r < POS_LIM);
  assign wr_o.addr    = pos_r[sss_pkg::ADDR_W-1:0];
  assign wr_o.data    = pat;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    bcd_nxt   = bcd_r;
    bin_nxt   = bin_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    hex_nxt   = hex_r;
    unique case (state_r)
      C_IDLE: begin
        if (start_i) begin
          hex_nxt  = hex_i;
          idx_nxt  = len_i - 4'd1;
          pos_nxt  = {3'b000, start_pos_i};
          seen_nxt = 1'b0;
          step_nxt = '0;
          bin_nxt  = value_i;
          if (hex_i) begin
            bcd_nxt = {{(sss_pkg::BCD_W - sss_pkg::VALUE_W){1'b0}}, value_i};
          end else begin
            bcd_nxt = '0;
          end
          if (len_i == 4'd0) begin
            state_nxt = C_IDLE;
          end else if (hex_i) begin
            state_nxt = C_PLACE;
          end else begin
            state_nxt = C_DABBLE;
          end
        end
      end
      C_DABBLE: begin
        bcd_nxt  = {bcd_adj[sss_pkg::BCD_W-2:0], bin_r[sss_pkg::VALUE_W-1]};
        bin_nxt  = {bin_r[sss_pkg::VALUE_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = C_PLACE;
        end
      end
      C_PLACE: begin
        seen_nxt = seen_r | (dig != 4'd0);
        idx_nxt  = idx_r - 4'd1;
        pos_nxt  = pos_r + 5'd1;
        if (idx_r == 4'd0) begin
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bcd_r  <= bcd_nxt;
    bin_r  <= bin_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    seen_r <= seen_nxt;
    hex_r  <= hex_nxt;
  end

endmodule

>>> rtl/core/seven_segment_scan_display.sv
// Scan tick: first bit valid the cycle after the request, 16 bits at one per cycle
//   while out_tready is high, ready again the cycle after the last bit is taken.
// Decimal write: 32 shift-and-add-3 steps in the converter, then one placement step
//   per window position, then a return to idle.
// Hex write: skips the dabble steps. Fill: all digits get raw_pattern.
// Reset (rst_n low, synchronous): every digit 0x40, scan position 0, no output.
module seven_segment_scan_display #(
  parameter int DIGITS = sss_pkg::DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // value[31:0], start_pos[33:32], window_len[37:34],
                                  // raw_pattern[45:38], zero pad
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // serial_bit[0], zero pad
  output logic        out_tlast   // latch_after
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SHIFT
  } state_t;

  localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(DIGITS - 1);

  state_t         state_r, state_nxt;
  logic [7:0]     store_r [DIGITS];
  logic [7:0]     store_nxt [DIGITS];
  logic [PW-1:0]  scan_pos_r, scan_pos_nxt;
  logic [15:0]    word_r, word_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic           in_acc;
  logic           out_acc;
  sss_pkg::op_t   in_op;
  logic [7:0]     col;
  logic           conv_start;
  logic           conv_busy;
  sss_pkg::wr_t   conv_wr;

  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign in_op      = sss_pkg::op_t'(in_tuser);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, word_r[15]};
  assign out_tlast  = (cnt_r == 4'd15);
  assign col        = 8'd1 << scan_pos_r;
  assign conv_start = in_acc && (in_op == sss_pkg::OP_DEC || in_op == sss_pkg::OP_HEX);

  // Digit conversion and window placement
  sss_conv #(
    .DIGITS (DIGITS)
  ) u_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (conv_start),
    .hex_i       (in_op == sss_pkg::OP_HEX),
    .value_i     (in_tdata[31:0]),
    .start_pos_i (in_tdata[33:32]),
    .len_i       (in_tdata[37:34]),
    .busy_o      (conv_busy),
    .wr_o        (conv_wr)
  );

  // Request decode, store updates and the serial shifter
  always_comb begin
    state_nxt     = state_r;
    store_nxt     = store_r;
    scan_pos_nxt  = scan_pos_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op) inside
            sss_pkg::OP_SCAN: begin
              word_nxt      = {store_r[scan_pos_r], col};
              cnt_nxt       = 4'd0;
              out_valid_nxt = 1'b1;
              state_nxt     = S_SHIFT;
            end
            sss_pkg::OP_DEC, sss_pkg::OP_HEX: begin
              state_nxt = S_CONV;
            end
            default: begin
              for (int i = 0; i < DIGITS; i++) begin
                store_nxt[i] = in_tdata[45:38];
              end
            end
          endcase
        end
      end
      S_CONV: begin
        if (conv_wr.en) begin
          store_nxt[conv_wr.addr[PW-1:0]] = conv_wr.data;
        end
        if (!conv_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (out_acc) begin
          if (cnt_r == 4'd15) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
            scan_pos_nxt  = (scan_pos_r == LAST_POS) ? '0 : scan_pos_r + 1'b1;
          end else begin
            word_nxt = {word_r[14:0], 1'b0};
            cnt_nxt  = cnt_r + 4'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_pos_r  <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= 4'd0;
      for (int i = 0; i < DIGITS; i++) begin
        store_r[i] <= sss_pkg::SEG_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      scan_pos_r  <= scan_pos_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      store_r     <= store_nxt;
    end
    word_r <= word_nxt;
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a scan is shifting out");

  a_wr_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (conv_wr.en || conv_busy) |-> (state_r == S_CONV))
    else $error("converter active outside conversion state");

  a_latch_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (!out_tvalid && in_tready))
    else $error("shifter did not stop after the latch bit");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_pos_r <= LAST_POS))
    else $error("scan position out of range");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Testbench for seven_segment_scan_display: directed and random requests with a
// built-in predictor of the digit store and scan position. Depends on sss_pkg.
module testbench;

  localparam int NUM_DIGITS   = 4;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_TICKS = 80;     // covers the longest write, with margin
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 104;

  // Segment codes for hex digits 0..F, digit 0 in the lowest byte
  localparam logic [127:0] SEG_CODES = {
    8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h90, 8'h80,
    8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
  };

  typedef struct packed {
    logic serial;
    logic latch;
  } shift_bit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;     // value[31:0], start_pos[33:32], window_len[37:34],
                                  // raw_pattern[45:38], zero pad
  logic [1:0]  in_tuser = sss_pkg::OP_SCAN; // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // serial_bit[0], zero pad
  logic        out_tlast;

  // Predictor state
  logic [7:0]  segment_mem [NUM_DIGITS];
  int          scan_pos;
  shift_bit_t  pending_bits[$];

  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;

  seven_segment_scan_display #(.DIGITS(NUM_DIGITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL seven_segment_scan_display");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: each shifted bit against the oldest expectation
  always @(posedge clk) begin
    shift_bit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bits.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: serial %b latch %b", out_tdata[0], out_tlast);
      end else begin
        want = pending_bits.pop_front();
        if (out_tdata[0] !== want.serial || out_tlast !== want.latch) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("mismatch: expected serial %b latch %b, got serial %b latch %b",
                     want.serial, want.latch, out_tdata[0], out_tlast);
        end
      end
    end
  end

  // Convert a value and place its low-order digits in the window
  task automatic place_window(input logic [31:0] value, input int start, input int len,
                              input bit hex_mode);
    logic [3:0]  digs [16];
    logic [31:0] rest;
    logic [7:0]  pat;
    bit          nonzero_seen;
    int          k, pos, last_end;
    logic [3:0]  d;
    rest = value;
    nonzero_seen = 1'b0;
    for (k = 0; k < 16; k++) digs[k] = 4'h0;
    for (k = 0; k < (hex_mode ? 8 : 10); k++) begin
      if (hex_mode) begin
        digs[k] = rest[3:0];
        rest = rest >> 4;
      end else begin
        digs[k] = 4'(rest % 10);
        rest = rest / 10;
      end
    end
    last_end = start + len;
    for (pos = start; pos < last_end; pos++) begin
      d = digs[last_end - 1 - pos];
      if (d != 4'h0) begin
        nonzero_seen = 1'b1;
        pat = SEG_CODES[d*8 +: 8];
      end else if (nonzero_seen || pos == last_end - 1 || hex_mode) begin
        pat = SEG_CODES[7:0];
      end else begin
        pat = sss_pkg::SEG_BLANK;
      end
      if (pos < NUM_DIGITS) segment_mem[pos] = pat;
    end
  endtask

  // Update the predicted state for one accepted request
  task automatic predict_request(input sss_pkg::op_t op, input logic [31:0] value,
                                 input logic [1:0] start, input logic [3:0] len,
                                 input logic [7:0] raw);
    logic [15:0] word;
    shift_bit_t  b;
    int          i;
    case (op)
      sss_pkg::OP_DEC:  place_window(value, int'(start), int'(len), 1'b0);
      sss_pkg::OP_HEX:  place_window(value, int'(start), int'(len), 1'b1);
      sss_pkg::OP_FILL: begin
        for (i = 0; i < NUM_DIGITS; i++) segment_mem[i] = raw;
      end
      default: begin
        word = {segment_mem[scan_pos], 8'(1 << scan_pos)};
        for (i = 0; i < 16; i++) begin
          b.serial = word[15 - i];
          b.latch  = (i == 15);
          pending_bits.push_back(b);
        end
        scan_pos = (scan_pos + 1 >= NUM_DIGITS) ? 0 : scan_pos + 1;
      end
    endcase
  endtask

  // Send one request; called just after a rising edge
  task automatic send_request(input sss_pkg::op_t op, input logic [31:0] value,
                              input logic [1:0] start, input logic [3:0] len,
                              input logic [7:0] raw);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, raw, len, start, value};
    do @(posedge clk); while (!in_tready);
    predict_request(op, value, start, len, raw);
  endtask

  // Hold off the sender until every scan result is out and the block is idle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Reset contents and scan wrap-around
  task automatic test_reset_scan();
    repeat (5) send_request(sss_pkg::OP_SCAN, $urandom, 2'($urandom), 4'($urandom),
                            8'($urandom));
  endtask

  // Fill with the extreme patterns
  task automatic test_fill();
    send_request(sss_pkg::OP_FILL, 32'h0, 2'd0, 4'd0, 8'h00);
    send_request(sss_pkg::OP_SCAN, 32'h0, 2'd0, 4'd0, 8'h00);
    send_request(sss_pkg::OP_FILL, 32'hFFFF_FFFF, 2'd3, 4'd15, 8'hFF);
  endtask

  // Decimal: full value, zero with blanking, empty window, window past the end
  task automatic test_decimal();
    send_request(sss_pkg::OP_DEC, 32'hFFFF_FFFF, 2'd0, 4'd4, 8'h00);
    send_request(sss_pkg::OP_DEC, 32'd0, 2'd0, 4'd4, 8'h00);
    send_request(sss_pkg::OP_DEC, 32'd1234, 2'd1, 4'd0, 8'hFF);
    send_request(sss_pkg::OP_DEC, 32'd4000000009, 2'd3, 4'd15, 8'h5A);
  endtask

  // Hex: zeros shown, long window past the eighth digit, offset window
  task automatic test_hex();
    send_request(sss_pkg::OP_HEX, 32'd0, 2'd0, 4'd4, 8'h00);
    send_request(sss_pkg::OP_HEX, 32'hFFFF_FFFF, 2'd2, 4'd10, 8'h00);
    send_request(sss_pkg::OP_HEX, 32'h1234_5678, 2'd1, 4'd3, 8'hA5);
    repeat (4) send_request(sss_pkg::OP_SCAN, 32'h0, 2'd0, 4'd0, 8'h00);
  endtask

  // Random traffic, writes mixed with scans
  task automatic test_random_traffic(input int count);
    sss_pkg::op_t op;
    logic [31:0]  value;
    logic [3:0]   len;
    int           pick, n;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50)      op = sss_pkg::OP_SCAN;
      else if (pick < 72) op = sss_pkg::OP_DEC;
      else if (pick < 94) op = sss_pkg::OP_HEX;
      else                op = sss_pkg::OP_FILL;
      case ($urandom_range(3))
        0:       value = $urandom;
        1:       value = $urandom_range(0, 99);
        2:       value = $urandom_range(0, 65535);
        default: value = 32'($urandom_range(1, 15)) << (4 * $urandom_range(0, 7));
      endcase
      if ($urandom_range(8) == 0) len = 4'($urandom_range(0, 15));
      else                        len = 4'($urandom_range(1, 10));
      send_request(op, value, 2'($urandom_range(0, 3)), len, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_DIGITS; i++) segment_mem[i] = sss_pkg::SEG_RESET;
    scan_pos = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_scan();
    test_fill();
    test_decimal();
    test_hex();

    send_gap_pct = 9;
    recv_stall_pct = 73;
    test_random_traffic(RANDOM_ITEMS);
    drain_results();

    send_gap_pct = 73;
    recv_stall_pct = 9;
    test_random_traffic(RANDOM_ITEMS);
    drain_results();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(RANDOM_ITEMS);

    drain_results();
    if (mismatches == 0 && pending_bits.size() == 0) begin
      $display("PASS seven_segment_scan_display");
    end else begin
      $display("FAIL seven_segment_scan_display");
    end
    $finish;
  end

endmodule
